>>> design/fscb_pkg.sv
`default_nettype none

package fscb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 80;
    localparam int SCREEN_HEIGHT_DEF = 25;
    localparam int MAX_SPRITE_DEF    = 64;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // field widths fixed by the interface
    localparam int POS_W    = 24;
    localparam int SIZE_W   = 7;
    localparam int GLYPH_W  = 8;
    localparam int COLOUR_W = 16;
    localparam int FB_W     = 11;

    // sprite position plus column offset, Q17.8
    localparam int SPOS_W   = 25;
    // wide signed work width for coordinate compares
    localparam int WIDE_W   = 28;
    // whole-cell index after dropping the fraction
    localparam int CELL_W   = WIDE_W - 8;
    // signed width of column + width * row
    localparam int ADDR_W   = 34;

    localparam logic [GLYPH_W-1:0] TRANSPARENT_GLYPH = 8'd255;

    localparam logic [1:0] ACT_SET    = 2'd0;
    localparam logic [1:0] ACT_FOLLOW = 2'd1;
    localparam logic [1:0] ACT_HEADER = 2'd2;
    localparam logic [1:0] ACT_PIXEL  = 2'd3;

    // one classified transaction between front and back
    typedef struct packed {
        logic                       cand;
        logic signed [SPOS_W-1:0]   ax;
        logic signed [SPOS_W-1:0]   ay;
        logic signed [POS_W-1:0]    cam_x;
        logic signed [POS_W-1:0]    cam_y;
        logic [GLYPH_W-1:0]         glyph;
        logic [COLOUR_W-1:0]        colour;
    } entry_t;

endpackage

`default_nettype wire

>>> design/fscb_front.sv
`default_nettype none

module fscb_front #(
    parameter int SCREEN_WIDTH  = fscb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = fscb_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAX_SPRITE    = fscb_pkg::MAX_SPRITE_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic                                 full,
    input  wire logic [1:0]                           action,
    input  wire logic signed [fscb_pkg::POS_W-1:0]    pos_x,
    input  wire logic signed [fscb_pkg::POS_W-1:0]    pos_y,
    input  wire logic [fscb_pkg::SIZE_W-1:0]          sprite_width,
    input  wire logic [fscb_pkg::SIZE_W-1:0]          sprite_height,
    input  wire logic [fscb_pkg::GLYPH_W-1:0]         glyph,
    input  wire logic [fscb_pkg::COLOUR_W-1:0]        colour,
    output logic                                      push,
    output fscb_pkg::entry_t                          push_entry
);

    localparam int W     = fscb_pkg::WIDE_W;
    localparam int PW    = fscb_pkg::POS_W;
    localparam int SW    = fscb_pkg::SIZE_W;
    localparam int CNT_W = (MAX_SPRITE > 64) ? 7 :
                           ((MAX_SPRITE > 1) ? $clog2(MAX_SPRITE) : 1);

    localparam logic signed [W-1:0] HALF_X = W'((SCREEN_WIDTH / 2) * 256);
    localparam logic signed [W-1:0] HALF_Y = W'((SCREEN_HEIGHT / 2) * 256);
    localparam logic signed [W-1:0] SCR_X  = W'(SCREEN_WIDTH * 256);
    localparam logic signed [W-1:0] SCR_Y  = W'(SCREEN_HEIGHT * 256);

    logic signed [PW-1:0]  camera_x_reg, camera_x_next;
    logic signed [PW-1:0]  camera_y_reg, camera_y_next;
    logic signed [PW-1:0]  sprite_left_x_reg, sprite_left_x_next;
    logic signed [PW-1:0]  sprite_top_y_reg, sprite_top_y_next;
    logic [SW-1:0]         cur_w_reg, cur_w_next;
    logic [SW-1:0]         cur_h_reg, cur_h_next;
    logic [CNT_W-1:0]      col_cnt_reg, col_cnt_next;
    logic [CNT_W-1:0]      row_cnt_reg, row_cnt_next;

    logic                  accept;
    logic signed [W-1:0]   px_w;
    logic signed [W-1:0]   py_w;
    logic signed [W-1:0]   cam_xw;
    logic signed [W-1:0]   cam_yw;
    logic signed [W-1:0]   ax_w;
    logic signed [W-1:0]   ay_w;
    logic [SW-1:0]         w_clamp;
    logic [SW-1:0]         h_clamp;
    logic [SW:0]           col_plus;
    logic [SW:0]           row_plus;

    function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        r = s;
        if (s == '0)
        begin
            r = SW'(1);
        end
        else if (9'(s) > 9'(MAX_SPRITE))
        begin
            r = SW'(MAX_SPRITE);
        end
        return r;
    endfunction

    // moves by a whole screen when the subject is more than half a screen away
    function automatic logic signed [PW-1:0] follow_axis(
        input logic signed [W-1:0] cam,
        input logic signed [W-1:0] subj,
        input logic signed [W-1:0] half,
        input logic signed [W-1:0] scr
    );
        logic signed [PW-1:0] r;
        r = PW'(cam);
        if (cam - half > subj)
        begin
            r = PW'(cam - scr);
        end
        else if (cam + half < subj)
        begin
            r = PW'(cam + scr);
        end
        return r;
    endfunction

    assign accept  = in_valid && !full;
    assign px_w    = W'(pos_x);
    assign py_w    = W'(pos_y);
    assign cam_xw  = W'(camera_x_reg);
    assign cam_yw  = W'(camera_y_reg);
    assign ax_w    = W'(sprite_left_x_reg) + W'({col_cnt_reg, 8'd0});
    assign ay_w    = W'(sprite_top_y_reg) + W'({row_cnt_reg, 8'd0});
    assign w_clamp = clamp_size(sprite_width);
    assign h_clamp = clamp_size(sprite_height);
    assign col_plus = (SW + 1)'(col_cnt_reg) + (SW + 1)'(1);
    assign row_plus = (SW + 1)'(row_cnt_reg) + (SW + 1)'(1);

    always_comb
    begin
        camera_x_next      = camera_x_reg;
        camera_y_next      = camera_y_reg;
        sprite_left_x_next = sprite_left_x_reg;
        sprite_top_y_next  = sprite_top_y_reg;
        cur_w_next         = cur_w_reg;
        cur_h_next         = cur_h_reg;
        col_cnt_next       = col_cnt_reg;
        row_cnt_next       = row_cnt_reg;
        if (accept)
        begin
            case (action)
                fscb_pkg::ACT_SET:
                begin
                    camera_x_next = pos_x;
                    camera_y_next = pos_y;
                end
                fscb_pkg::ACT_FOLLOW:
                begin
                    camera_x_next = follow_axis(cam_xw, px_w, HALF_X, SCR_X);
                    camera_y_next = follow_axis(cam_yw, py_w, HALF_Y, SCR_Y);
                end
                fscb_pkg::ACT_HEADER:
                begin
                    cur_w_next         = w_clamp;
                    cur_h_next         = h_clamp;
                    sprite_left_x_next = PW'(px_w - W'({w_clamp, 7'd0}));
                    sprite_top_y_next  = PW'(py_w - W'({h_clamp, 7'd0}));
                    col_cnt_next       = '0;
                    row_cnt_next       = '0;
                end
                fscb_pkg::ACT_PIXEL:
                begin
                    if (col_plus >= {1'b0, cur_w_reg})
                    begin
                        col_cnt_next = '0;
                        if (row_plus >= {1'b0, cur_h_reg})
                        begin
                            row_cnt_next = '0;
                        end
                        else
                        begin
                            row_cnt_next = CNT_W'(row_plus);
                        end
                    end
                    else
                    begin
                        col_cnt_next = CNT_W'(col_plus);
                    end
                end
                default:
                begin
                    camera_x_next = camera_x_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        push              = accept;
        push_entry.cand   = (action == fscb_pkg::ACT_PIXEL) &&
                            (glyph != fscb_pkg::TRANSPARENT_GLYPH);
        push_entry.ax     = fscb_pkg::SPOS_W'(ax_w);
        push_entry.ay     = fscb_pkg::SPOS_W'(ay_w);
        push_entry.cam_x  = camera_x_reg;
        push_entry.cam_y  = camera_y_reg;
        push_entry.glyph  = glyph;
        push_entry.colour = colour;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_x_reg      <= '0;
            camera_y_reg      <= '0;
            sprite_left_x_reg <= '0;
            sprite_top_y_reg  <= '0;
            cur_w_reg         <= SW'(1);
            cur_h_reg         <= SW'(1);
            col_cnt_reg       <= '0;
            row_cnt_reg       <= '0;
        end
        else
        begin
            camera_x_reg      <= camera_x_next;
            camera_y_reg      <= camera_y_next;
            sprite_left_x_reg <= sprite_left_x_next;
            sprite_top_y_reg  <= sprite_top_y_next;
            cur_w_reg         <= cur_w_next;
            cur_h_reg         <= cur_h_next;
            col_cnt_reg       <= col_cnt_next;
            row_cnt_reg       <= row_cnt_next;
        end
    end

    a_header_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == fscb_pkg::ACT_HEADER) |=>
        (col_cnt_reg == '0 && row_cnt_reg == '0))
        else $error("sprite counters not restarted by header");

    a_col_in_sprite: assert property (@(posedge clk) disable iff (!rst_n)
        ((SW + 1)'(col_cnt_reg) < {1'b0, cur_w_reg}) &&
        ((SW + 1)'(row_cnt_reg) < {1'b0, cur_h_reg}))
        else $error("sprite counter beyond sprite size");

endmodule

`default_nettype wire

>>> design/fscb_queue.sv
`default_nettype none

module fscb_queue #(
    parameter int DEPTH = fscb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire fscb_pkg::entry_t  push_entry,
    output logic                   full,
    input  wire logic              pop,
    output logic                   pop_valid,
    output fscb_pkg::entry_t       pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    fscb_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == (PTR_W + 1)'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PTR_W + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("transaction pushed into a full queue");

endmodule

`default_nettype wire

>>> design/fscb_back.sv
`default_nettype none

module fscb_back #(
    parameter int SCREEN_WIDTH  = fscb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = fscb_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             q_valid,
    input  wire fscb_pkg::entry_t                 q_entry,
    output logic                                  q_pop,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  write_valid,
    output logic [fscb_pkg::FB_W-1:0]             fb_address,
    output logic [fscb_pkg::GLYPH_W-1:0]          out_glyph,
    output logic [fscb_pkg::COLOUR_W-1:0]         out_colour
);

    localparam int W  = fscb_pkg::WIDE_W;
    localparam int CW = fscb_pkg::CELL_W;
    localparam int AW = fscb_pkg::ADDR_W;

    localparam logic signed [W-1:0]  HALF_X = W'((SCREEN_WIDTH / 2) * 256);
    localparam logic signed [W-1:0]  HALF_Y = W'((SCREEN_HEIGHT / 2) * 256);
    localparam logic signed [AW-1:0] SW_A   = AW'(SCREEN_WIDTH);
    localparam logic signed [AW-1:0] AREA_A = AW'(SCREEN_WIDTH * SCREEN_HEIGHT);

    typedef struct packed {
        logic                                cand;
        logic signed [CW-1:0]                col;
        logic signed [CW-1:0]                row;
        logic [fscb_pkg::GLYPH_W-1:0]        glyph;
        logic [fscb_pkg::COLOUR_W-1:0]       colour;
    } stage_t;

    stage_t                          s1_reg, s1_next;
    logic                            s1_valid_reg, s1_valid_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            write_valid_reg, write_valid_next;
    logic [fscb_pkg::FB_W-1:0]       fb_address_reg, fb_address_next;
    logic [fscb_pkg::GLYPH_W-1:0]    out_glyph_reg, out_glyph_next;
    logic [fscb_pkg::COLOUR_W-1:0]   out_colour_reg, out_colour_next;

    logic                            out_adv;
    logic                            s1_adv;
    logic signed [W-1:0]             ax_w;
    logic signed [W-1:0]             ay_w;
    logic signed [W-1:0]             cam_xw;
    logic signed [W-1:0]             cam_yw;
    logic signed [W-1:0]             cell_x;
    logic signed [W-1:0]             cell_y;
    logic                            in_x;
    logic                            in_y;
    logic signed [AW-1:0]            addr;
    logic                            addr_ok;

    // whole cells, fraction dropped toward zero
    function automatic logic signed [CW-1:0] trunc_cell(input logic signed [W-1:0] v);
        logic signed [CW-1:0] q;
        q = CW'(v >>> 8);
        if (v < 0 && v[7:0] != 8'd0)
        begin
            q = q + CW'(1);
        end
        return q;
    endfunction

    assign out_adv = !out_valid_reg || !out_stall;
    assign s1_adv  = !s1_valid_reg || out_adv;
    assign q_pop   = q_valid && s1_adv;

    // view test and screen-relative cell
    always_comb
    begin
        ax_w   = W'(q_entry.ax);
        ay_w   = W'(q_entry.ay);
        cam_xw = W'(q_entry.cam_x);
        cam_yw = W'(q_entry.cam_y);
        cell_x = {trunc_cell(ax_w), 8'd0};
        cell_y = {trunc_cell(ay_w), 8'd0};
        in_x   = !(cell_x < cam_xw - HALF_X) && !(cell_x >= cam_xw + HALF_X);
        in_y   = !(cell_y < cam_yw - HALF_Y) && !(cell_y >= cam_yw + HALF_Y);

        s1_next.cand   = q_entry.cand && in_x && in_y;
        s1_next.col    = trunc_cell(HALF_X + ax_w - cam_xw);
        s1_next.row    = trunc_cell(HALF_Y + ay_w - cam_yw);
        s1_next.glyph  = q_entry.glyph;
        s1_next.colour = q_entry.colour;

        s1_valid_next = s1_adv ? q_valid : s1_valid_reg;
    end

    // frame-buffer address and bounds
    always_comb
    begin
        addr    = AW'(s1_reg.col) + AW'(s1_reg.row) * SW_A;
        addr_ok = s1_reg.cand && !addr[AW-1] && (addr < AREA_A);

        write_valid_next = addr_ok;
        fb_address_next  = addr_ok ? fscb_pkg::FB_W'(addr) : '0;
        out_glyph_next   = addr_ok ? s1_reg.glyph : '0;
        out_colour_next  = addr_ok ? s1_reg.colour : '0;

        out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_reg <= s1_next;
        end
        if (out_adv && s1_valid_reg)
        begin
            write_valid_reg <= write_valid_next;
            fb_address_reg  <= fb_address_next;
            out_glyph_reg   <= out_glyph_next;
            out_colour_reg  <= out_colour_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign write_valid = write_valid_reg;
    assign fb_address  = fb_address_reg;
    assign out_glyph   = out_glyph_reg;
    assign out_colour  = out_colour_reg;

    a_write_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && write_valid_reg) |-> (AW'(fb_address_reg) < AREA_A))
        else $error("frame-buffer write outside the buffer");

endmodule

`default_nettype wire

>>> design/flip_screen_camera_sprite_blitter_top.sv
`default_nettype none

// flip-screen camera with a color-keyed sprite blitter. every input transaction
// (set camera, follow subject, sprite header, sprite pixel) yields exactly one
// output transaction; only pixels that are not glyph 255, lie inside the camera
// view and map into the frame buffer come out with write_valid high, all others
// carry write_valid low and zero payload. one transaction per cycle is taken
// and delivered sustained while out_stall stays low; when nothing stalls, a
// transaction passes the queue, the view-test stage and the address/output
// register on its way to the outputs. the front updates camera and sprite
// state in the accept cycle, so later pixels always see the camera as it
// stands at their own time. in_stall rises only when the queue between front
// and back is full, which happens only while out_stall holds the back end.

module flip_screen_camera_sprite_blitter_top #(
    parameter int SCREEN_WIDTH  = fscb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = fscb_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAX_SPRITE    = fscb_pkg::MAX_SPRITE_DEF,
    parameter int QUEUE_DEPTH   = fscb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [1:0]                           action,
    input  wire logic signed [fscb_pkg::POS_W-1:0]    pos_x,
    input  wire logic signed [fscb_pkg::POS_W-1:0]    pos_y,
    input  wire logic [fscb_pkg::SIZE_W-1:0]          sprite_width,
    input  wire logic [fscb_pkg::SIZE_W-1:0]          sprite_height,
    input  wire logic [fscb_pkg::GLYPH_W-1:0]         glyph,
    input  wire logic [fscb_pkg::COLOUR_W-1:0]        colour,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      write_valid,
    output logic [fscb_pkg::FB_W-1:0]                 fb_address,
    output logic [fscb_pkg::GLYPH_W-1:0]              out_glyph,
    output logic [fscb_pkg::COLOUR_W-1:0]             out_colour
);

    logic              q_full;
    logic              push;
    fscb_pkg::entry_t  push_entry;
    logic              q_pop;
    logic              q_valid;
    fscb_pkg::entry_t  q_entry;

    assign in_stall = q_full;

    fscb_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAX_SPRITE    (MAX_SPRITE)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .full          (q_full),
        .action        (action),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .sprite_width  (sprite_width),
        .sprite_height (sprite_height),
        .glyph         (glyph),
        .colour        (colour),
        .push          (push),
        .push_entry    (push_entry)
    );

    fscb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    fscb_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .write_valid (write_valid),
        .fb_address  (fb_address),
        .out_glyph   (out_glyph),
        .out_colour  (out_colour)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_flip_screen_camera_sprite_blitter_top.sv
`timescale 1ns / 1ps

module tb_flip_screen_camera_sprite_blitter_top;

    localparam int SCR_W       = fscb_pkg::SCREEN_WIDTH_DEF;
    localparam int SCR_H       = fscb_pkg::SCREEN_HEIGHT_DEF;
    localparam int MAX_SPRITE  = fscb_pkg::MAX_SPRITE_DEF;
    localparam int POS_W       = fscb_pkg::POS_W;
    localparam int SIZE_W      = fscb_pkg::SIZE_W;
    localparam int GLYPH_W     = fscb_pkg::GLYPH_W;
    localparam int COLOUR_W    = fscb_pkg::COLOUR_W;
    localparam int FB_W        = fscb_pkg::FB_W;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic                write_valid;
        logic [FB_W-1:0]     fb_address;
        logic [GLYPH_W-1:0]  glyph;
        logic [COLOUR_W-1:0] colour;
    } cell_write_t;

    class blit_scoreboard;
        longint      camera_x = 0;
        longint      camera_y = 0;
        longint      sprite_left_x = 0;
        longint      sprite_top_y = 0;
        int unsigned cur_w = 1;
        int unsigned cur_h = 1;
        int unsigned col_cnt = 0;
        int unsigned row_cnt = 0;
        cell_write_t pending_writes[$];
        int unsigned mismatches = 0;
        int unsigned results_checked = 0;
        int unsigned cells_written = 0;

        function longint wrap24(longint v);
            logic signed [POS_W-1:0] t;
            t = v[POS_W-1:0];
            return t;
        endfunction

        function int unsigned clamp_size(logic [SIZE_W-1:0] s);
            if (s == 0)
                return 1;
            if (s > MAX_SPRITE)
                return MAX_SPRITE;
            return s;
        endfunction

        // flip by a whole screen once the subject is more than half a screen away
        function longint follow_axis(longint cam, longint subj, int scr);
            longint half;
            half = longint'(scr / 2) * 256;
            if (cam - half > subj)
                return wrap24(cam - longint'(scr) * 256);
            if (cam + half < subj)
                return wrap24(cam + longint'(scr) * 256);
            return cam;
        endfunction

        function bit axis_in_view(longint a, longint cam, int scr);
            longint whole;
            longint half;
            whole = (a / 256) * 256;
            half = longint'(scr / 2) * 256;
            return (whole >= cam - half) && (whole < cam + half);
        endfunction

        function void note_transaction(logic [1:0] act, logic signed [POS_W-1:0] px,
                                       logic signed [POS_W-1:0] py,
                                       logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                                       logic [GLYPH_W-1:0] g, logic [COLOUR_W-1:0] c);
            longint      ax;
            longint      ay;
            longint      col;
            longint      row;
            longint      addr;
            cell_write_t res;
            res = '{default: 0};
            case (act)
                fscb_pkg::ACT_SET:
                begin
                    camera_x = px;
                    camera_y = py;
                end
                fscb_pkg::ACT_FOLLOW:
                begin
                    camera_x = follow_axis(camera_x, px, SCR_W);
                    camera_y = follow_axis(camera_y, py, SCR_H);
                end
                fscb_pkg::ACT_HEADER:
                begin
                    cur_w = clamp_size(w);
                    cur_h = clamp_size(h);
                    sprite_left_x = wrap24(px - longint'(cur_w) * 128);
                    sprite_top_y = wrap24(py - longint'(cur_h) * 128);
                    col_cnt = 0;
                    row_cnt = 0;
                end
                default:
                begin
                    ax = sprite_left_x + longint'(col_cnt) * 256;
                    ay = sprite_top_y + longint'(row_cnt) * 256;
                    if (g != fscb_pkg::TRANSPARENT_GLYPH
                        && axis_in_view(ax, camera_x, SCR_W)
                        && axis_in_view(ay, camera_y, SCR_H))
                    begin
                        col = (longint'(SCR_W / 2) * 256 + ax - camera_x) / 256;
                        row = (longint'(SCR_H / 2) * 256 + ay - camera_y) / 256;
                        addr = col + longint'(SCR_W) * row;
                        if (addr >= 0 && addr < longint'(SCR_W) * SCR_H)
                        begin
                            res.write_valid = 1'b1;
                            res.fb_address = addr[FB_W-1:0];
                            res.glyph = g;
                            res.colour = c;
                            cells_written++;
                        end
                    end
                    // raster order, wrapping back to the top-left after the last pixel
                    col_cnt++;
                    if (col_cnt >= cur_w)
                    begin
                        col_cnt = 0;
                        row_cnt++;
                        if (row_cnt >= cur_h)
                            row_cnt = 0;
                    end
                end
            endcase
            pending_writes.push_back(res);
        endfunction

        function void check_write(logic wv, logic [FB_W-1:0] addr, logic [GLYPH_W-1:0] g,
                                  logic [COLOUR_W-1:0] c);
            cell_write_t want;
            results_checked++;
            if (pending_writes.size() == 0)
            begin
                $error("result with nothing outstanding: write_valid %0b fb_address %0d",
                       wv, addr);
                mismatches++;
                return;
            end
            want = pending_writes.pop_front();
            if (wv !== want.write_valid)
            begin
                $error("write_valid: expected %0b, got %0b", want.write_valid, wv);
                mismatches++;
            end
            if (addr !== want.fb_address)
            begin
                $error("fb_address: expected %0d, got %0d", want.fb_address, addr);
                mismatches++;
            end
            if (g !== want.glyph)
            begin
                $error("out_glyph: expected 0x%02h, got 0x%02h", want.glyph, g);
                mismatches++;
            end
            if (c !== want.colour)
            begin
                $error("out_colour: expected 0x%04h, got 0x%04h", want.colour, c);
                mismatches++;
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [1:0]                 action = fscb_pkg::ACT_SET;
    logic signed [POS_W-1:0]    pos_x = '0;
    logic signed [POS_W-1:0]    pos_y = '0;
    logic [SIZE_W-1:0]          sprite_width = '0;
    logic [SIZE_W-1:0]          sprite_height = '0;
    logic [GLYPH_W-1:0]         glyph = '0;
    logic [COLOUR_W-1:0]        colour = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       write_valid;
    logic [FB_W-1:0]            fb_address;
    logic [GLYPH_W-1:0]         out_glyph;
    logic [COLOUR_W-1:0]        out_colour;

    blit_scoreboard sb = new;
    int unsigned    send_idle_pct = 14;
    int unsigned    recv_idle_pct = 68;
    int unsigned    items_sent = 0;
    int unsigned    quiet_cycles = 0;

    flip_screen_camera_sprite_blitter_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .sprite_width  (sprite_width),
        .sprite_height (sprite_height),
        .glyph         (glyph),
        .colour        (colour),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_valid   (write_valid),
        .fb_address    (fb_address),
        .out_glyph     (out_glyph),
        .out_colour    (out_colour)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_write(write_valid, fb_address, out_glyph, out_colour);
    end

    // no transaction on either side for too long means the block is hung
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [POS_W-1:0] px,
                             input logic [POS_W-1:0] py, input logic [SIZE_W-1:0] w,
                             input logic [SIZE_W-1:0] h, input logic [GLYPH_W-1:0] g,
                             input logic [COLOUR_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        pos_x <= px;
        pos_y <= py;
        sprite_width <= w;
        sprite_height <= h;
        glyph <= g;
        colour <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_transaction(act, px, py, w, h, g, c);
        items_sent++;
    endtask

    function automatic logic [POS_W-1:0] near_pos(longint centre, int unsigned span);
        longint off;
        off = longint'($urandom_range(2 * span * 256)) - longint'(span) * 256;
        return POS_W'(centre + off);
    endfunction

    function automatic logic [SIZE_W-1:0] sprite_dim();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 85)
            return SIZE_W'($urandom_range(8, 1));
        if (r < 95)
            return SIZE_W'($urandom_range(64, 9));
        return SIZE_W'($urandom());
    endfunction

    task automatic move_camera();
        logic [1:0] act;
        act = $urandom_range(1) ? fscb_pkg::ACT_SET : fscb_pkg::ACT_FOLLOW;
        if ($urandom_range(4) == 0)
            send_item(act, POS_W'($urandom()), POS_W'($urandom()), SIZE_W'($urandom()),
                      SIZE_W'($urandom()), GLYPH_W'($urandom()), COLOUR_W'($urandom()));
        else
            send_item(act, near_pos(sb.camera_x, 90), near_pos(sb.camera_y, 30),
                      SIZE_W'($urandom()), SIZE_W'($urandom()), GLYPH_W'($urandom()),
                      COLOUR_W'($urandom()));
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned first;
        int unsigned pick;
        int unsigned n_pix;
        logic [GLYPH_W-1:0] g;
        first = items_sent;
        while (items_sent - first < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                move_camera();
            end
            else if (pick < 88)
            begin
                // header near the view, then its pixels in raster order
                send_item(fscb_pkg::ACT_HEADER, near_pos(sb.camera_x, 50),
                          near_pos(sb.camera_y, 20), sprite_dim(), sprite_dim(),
                          GLYPH_W'($urandom()), COLOUR_W'($urandom()));
                n_pix = sb.cur_w * sb.cur_h;
                if ($urandom_range(6) == 0)
                    n_pix = $urandom_range(n_pix + 4);
                if (n_pix > 96)
                    n_pix = 96;
                for (int i = 0; i < n_pix; i++)
                begin
                    if ($urandom_range(39) == 0)
                        move_camera();
                    g = ($urandom_range(4) == 0) ? fscb_pkg::TRANSPARENT_GLYPH
                                                 : GLYPH_W'($urandom_range(254));
                    send_item(fscb_pkg::ACT_PIXEL, POS_W'($urandom()), POS_W'($urandom()),
                              SIZE_W'($urandom()), SIZE_W'($urandom()), g,
                              COLOUR_W'($urandom()));
                end
            end
            else
            begin
                send_item(2'($urandom()), POS_W'($urandom()), POS_W'($urandom()),
                          SIZE_W'($urandom()), SIZE_W'($urandom()), GLYPH_W'($urandom()),
                          COLOUR_W'($urandom()));
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pixel straight out of reset
        send_item(fscb_pkg::ACT_PIXEL, 24'h0, 24'h0, 7'd0, 7'd0, 8'd0, 16'h0000);
        // fractional camera, size-zero sprite on the top-left edge of the view
        send_item(fscb_pkg::ACT_SET, 24'd128, 24'd128, 7'd0, 7'd0, 8'd0, 16'h0000);
        send_item(fscb_pkg::ACT_HEADER, POS_W'(128 - 40 * 256), POS_W'(128 - 12 * 256),
                  7'd0, 7'd0, 8'd0, 16'h0000);
        send_item(fscb_pkg::ACT_PIXEL, 24'h0, 24'h0, 7'd0, 7'd0, 8'h41, 16'hFFFF);
        // 2x2 sprite on the bottom-right edge, one extra pixel redraws the first cell
        send_item(fscb_pkg::ACT_HEADER, POS_W'(128 + 40 * 256), POS_W'(128 + 12 * 256),
                  7'd2, 7'd2, 8'd0, 16'h0000);
        send_item(fscb_pkg::ACT_PIXEL, 24'h0, 24'h0, 7'd0, 7'd0, 8'd254, 16'h0000);
        send_item(fscb_pkg::ACT_PIXEL, 24'h0, 24'h0, 7'd0, 7'd0,
                  fscb_pkg::TRANSPARENT_GLYPH, 16'hFFFF);
        send_item(fscb_pkg::ACT_PIXEL, 24'h0, 24'h0, 7'd0, 7'd0, 8'h80, 16'h7FFF);
        send_item(fscb_pkg::ACT_PIXEL, 24'h0, 24'h0, 7'd0, 7'd0, 8'h7F, 16'h8000);
        send_item(fscb_pkg::ACT_PIXEL, 24'h0, 24'h0, 7'd0, 7'd0, 8'h01, 16'h0001);
        // oversize header clamps to the largest sprite
        send_item(fscb_pkg::ACT_HEADER, 24'h0, 24'h0, 7'h7F, 7'h7F, 8'd0, 16'h0000);
        send_item(fscb_pkg::ACT_PIXEL, 24'h0, 24'h0, 7'd0, 7'd0,
                  fscb_pkg::TRANSPARENT_GLYPH, 16'h1234);
        send_item(fscb_pkg::ACT_PIXEL, 24'h0, 24'h0, 7'd0, 7'd0, 8'h20, 16'h4321);
        // camera extremes and a follow that wraps on both axes
        send_item(fscb_pkg::ACT_SET, 24'h800000, 24'h7FFFFF, 7'd0, 7'd0, 8'd0, 16'h0000);
        send_item(fscb_pkg::ACT_SET, 24'h7FC000, 24'h801000, 7'd0, 7'd0, 8'd0, 16'h0000);
        send_item(fscb_pkg::ACT_FOLLOW, 24'h7FFFFF, 24'h800000, 7'd0, 7'd0, 8'd0,
                  16'h0000);
        send_item(fscb_pkg::ACT_FOLLOW, 24'h0, 24'h0, 7'd0, 7'd0, 8'd0, 16'h0000);
        // sprite corner wraps below the most negative position
        send_item(fscb_pkg::ACT_HEADER, 24'h800000, 24'h800000, 7'd1, 7'd1, 8'd0,
                  16'h0000);
        send_item(fscb_pkg::ACT_PIXEL, 24'h0, 24'h0, 7'd0, 7'd0, 8'h55, 16'hAAAA);
        // camera moves between pixels of one sprite
        send_item(fscb_pkg::ACT_SET, 24'h0, 24'h0, 7'd0, 7'd0, 8'd0, 16'h0000);
        send_item(fscb_pkg::ACT_HEADER, 24'h0, 24'h0, 7'd3, 7'd1, 8'd0, 16'h0000);
        send_item(fscb_pkg::ACT_PIXEL, 24'h0, 24'h0, 7'd0, 7'd0, 8'h30, 16'h0F0F);
        send_item(fscb_pkg::ACT_SET, POS_W'(5 * 256), 24'h0, 7'd0, 7'd0, 8'd0, 16'h0000);
        send_item(fscb_pkg::ACT_PIXEL, 24'h0, 24'h0, 7'd0, 7'd0, 8'h31, 16'hF0F0);
        send_item(fscb_pkg::ACT_FOLLOW, POS_W'(-41 * 256), POS_W'(13 * 256), 7'd0, 7'd0,
                  8'd0, 16'h0000);
        send_item(fscb_pkg::ACT_PIXEL, 24'h0, 24'h0, 7'd0, 7'd0, 8'h32, 16'h00FF);

        run_random(370);
        send_idle_pct = 68;
        recv_idle_pct = 14;
        run_random(370);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(370);

        in_valid <= 1'b0;
        while (sb.pending_writes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("drove %0d transactions of all four kinds under three stall mixes",
                 items_sent);
        $display("checked %0d results, %0d of them frame-buffer writes", sb.results_checked,
                 sb.cells_written);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
